>>> sv/skg_pkg.sv
// shared types, constants and helpers for the shake gesture key selector
`timescale 1ns / 1ps

package skg_pkg;

	// default parameter values
	localparam int DEF_SAMPLE_BITS = 16;
	localparam int DEF_TIMER_BITS  = 25;

	// configuration register indexes
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_TIMEOUT   = 2'd1;
	localparam logic [1:0] REG_SEED      = 2'd2;

	// configuration register widths and reset values
	localparam int THRESH_W  = 16;
	localparam int TIMEOUT_W = 24;
	localparam int SEED_W    = 16;
	localparam int CFG_W     = 24;
	localparam logic [THRESH_W-1:0]   THRESH_RST  = 16'd250;
	localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST = 24'd350000;
	localparam logic [SEED_W-1:0]     SEED_RST    = 16'd44257;
	localparam logic [2*THRESH_W-1:0] THR2_RST    = 32'd62500;

	// mode codes
	localparam logic [1:0] MODE_IDLE     = 2'd0;
	localparam logic [1:0] MODE_SHAKING  = 2'd1;
	localparam logic [1:0] MODE_SETTLING = 2'd2;

	// letter and key constants
	localparam logic [6:0]  LETTER_BASE  = 7'd65;
	localparam logic [6:0]  USAGE_OFFSET = 7'd61;
	localparam logic [15:0] LFSR_MASK    = 16'hB400;
	localparam int          ELAPSED_W    = 16;

	// one resolved sample handed from the front pipeline to the mode logic
	typedef struct packed {
		logic                 valid;
		logic                 is_strong;
		logic                 dot_neg;
		logic [ELAPSED_W-1:0] elapsed;
	} skg_item_t;

	// one step of the right-shifting galois lfsr
	function automatic logic [15:0] lfsr_step(input logic [15:0] s);
		logic [15:0] n;
		n = {1'b0, s[15:1]};
		if (s[0]) begin
			n = n ^ LFSR_MASK;
		end
		return n;
	endfunction

	// value mod 26: nibble fold mod 13, then fix parity for the factor two
	function automatic logic [4:0] mod26(input logic [15:0] v);
		logic [7:0] s;
		logic [5:0] t;
		logic [4:0] r13;
		s = 8'(v[3:0]) + 8'(v[7:4]) * 8'd3 + 8'(v[11:8]) * 8'd9 + 8'(v[15:12]);
		t = 6'(s[3:0]) + 6'(s[7:4]) * 6'd3;
		if (t >= 6'd39) begin
			r13 = 5'(t - 6'd39);
		end else if (t >= 6'd26) begin
			r13 = 5'(t - 6'd26);
		end else if (t >= 6'd13) begin
			r13 = 5'(t - 6'd13);
		end else begin
			r13 = 5'(t);
		end
		if (r13[0] != v[0]) begin
			r13 = r13 + 5'd13;
		end
		return r13;
	endfunction

endpackage

>>> sv/skg_front.sv
// front pipeline: input capture, squared magnitude test and dot product sign
`timescale 1ns / 1ps

module skg_front import skg_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic signed [SAMPLE_BITS-1:0] accel_x,
	input  logic signed [SAMPLE_BITS-1:0] accel_y,
	input  logic signed [SAMPLE_BITS-1:0] accel_z,
	input  logic [ELAPSED_W-1:0]        elapsed_us,
	input  logic [THRESH_W-1:0]         shake_threshold,
	output skg_item_t                   item
);

	localparam int PROD_W = 2 * SAMPLE_BITS;
	localparam int MAG_W  = PROD_W + 2;
	localparam int THR_W  = 2 * THRESH_W;
	localparam int CMP_W  = (MAG_W > THR_W) ? MAG_W : THR_W;

	logic                          v_s1, v_s2, v_s3;
	logic signed [SAMPLE_BITS-1:0] a_s1 [3];
	logic signed [SAMPLE_BITS-1:0] a_s2 [3];
	logic [ELAPSED_W-1:0]          el_s1, el_s2, el_s3;
	logic [PROD_W-1:0]             sq_s2 [3];
	logic signed [PROD_W-1:0]      prod_s3 [3];
	logic                          strong_s3;
	logic signed [SAMPLE_BITS-1:0] lastv_q [3];
	logic [THR_W-1:0]              thr2_q;
	logic [PROD_W-1:0]             sq_c [3];
	logic signed [PROD_W-1:0]      prod_c [3];
	logic [MAG_W-1:0]              mag_c;
	logic                          strong_c;
	logic [MAG_W-1:0]              dot_c;
	logic                          valid_s4;
	logic                          strong_s4;
	logic                          neg_s4;
	logic [ELAPSED_W-1:0]          el_s4;

	// squared threshold, refreshed every cycle from the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr2_q <= THR2_RST;
		end else begin
			thr2_q <= THR_W'(shake_threshold) * THR_W'(shake_threshold);
		end
	end

	// stage one: capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1[0] <= accel_x;
			a_s1[1] <= accel_y;
			a_s1[2] <= accel_z;
			el_s1   <= elapsed_us;
		end
	end

	// squares of each axis
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_c[i] = PROD_W'(PROD_W'(a_s1[i]) * PROD_W'(a_s1[i]));
		end
	end

	// stage two: registered squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s2[i]  <= a_s1[i];
				sq_s2[i] <= sq_c[i];
			end
			el_s2 <= el_s1;
		end
	end

	// magnitude test and products with the last strong vector
	always_comb begin
		mag_c = MAG_W'(sq_s2[0]) + MAG_W'(sq_s2[1]) + MAG_W'(sq_s2[2]);
		strong_c = CMP_W'(mag_c) >= CMP_W'(thr2_q);
		for (int i = 0; i < 3; i++) begin
			prod_c[i] = PROD_W'(PROD_W'(a_s2[i]) * PROD_W'(lastv_q[i]));
		end
	end

	// last strong sample; in shaking and settling it equals the stored vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				lastv_q[i] <= '0;
			end
		end else if (en && v_s2 && strong_c) begin
			for (int i = 0; i < 3; i++) begin
				lastv_q[i] <= a_s2[i];
			end
		end
	end

	// stage three: strong flag and products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			strong_s3 <= strong_c;
			for (int i = 0; i < 3; i++) begin
				prod_s3[i] <= prod_c[i];
			end
			el_s3 <= el_s2;
		end
	end

	// dot product sum, sign extended
	assign dot_c = {{2{prod_s3[0][PROD_W-1]}}, prod_s3[0]}
		+ {{2{prod_s3[1][PROD_W-1]}}, prod_s3[1]}
		+ {{2{prod_s3[2][PROD_W-1]}}, prod_s3[2]};

	// stage four: resolved sample for the mode logic
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			strong_s4 <= strong_s3;
			neg_s4    <= dot_c[MAG_W-1];
			el_s4     <= el_s3;
		end
	end

	assign item = '{valid: valid_s4, is_strong: strong_s4, dot_neg: neg_s4, elapsed: el_s4};

endmodule

>>> sv/skg_core.sv
// mode state machine, letter lfsr, settle timer and result register
`timescale 1ns / 1ps

module skg_core import skg_pkg::*; #(
	parameter int TIMER_BITS = DEF_TIMER_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  skg_item_t            item,
	input  logic [TIMEOUT_W-1:0] settle_timeout_us,
	input  logic                 seed_load,
	input  logic [SEED_W-1:0]    random_seed,
	output logic                 res_valid,
	output logic [1:0]           mode_now,
	output logic [6:0]           shown_letter,
	output logic                 key_valid,
	output logic [6:0]           key_ascii,
	output logic [4:0]           key_usage
);

	localparam int TC_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;

	logic [1:0]            mode_q;
	logic [4:0]            letter_q;
	logic [TIMER_BITS-1:0] timer_q;
	logic [15:0]           lfsr_q;
	logic                  res_valid_q;
	logic [1:0]            mode_res_q;
	logic [6:0]            shown_q;
	logic                  key_q;
	logic [6:0]            ascii_q;
	logic [4:0]            usage_q;

	logic [1:0]            mode_d;
	logic [TIMER_BITS-1:0] timer_d;
	logic [TIMER_BITS:0]   timer_sum;
	logic                  pick;
	logic                  key_d;
	logic [15:0]           lfsr_nxt;
	logic [4:0]            letter_d;
	logic [6:0]            ascii_d;

	assign lfsr_nxt = lfsr_step(lfsr_q);

	// next mode, timer and letter pick
	always_comb begin
		mode_d    = mode_q;
		timer_d   = timer_q;
		pick      = 1'b0;
		key_d     = 1'b0;
		timer_sum = {1'b0, timer_q} + (TIMER_BITS + 1)'(item.elapsed);
		unique case (mode_q)
			MODE_SHAKING: begin
				if (!item.is_strong) begin
					mode_d  = MODE_SETTLING;
					timer_d = '0;
				end else begin
					pick = item.dot_neg;
				end
			end
			MODE_SETTLING: begin
				if (item.is_strong) begin
					mode_d = MODE_SHAKING;
					pick   = item.dot_neg;
				end else begin
					timer_d = timer_sum[TIMER_BITS] ? '1 : timer_sum[TIMER_BITS-1:0];
					if (TC_W'(timer_d) > TC_W'(settle_timeout_us)) begin
						key_d  = 1'b1;
						mode_d = MODE_IDLE;
					end
				end
			end
			default: begin
				mode_d = MODE_IDLE;
				if (item.is_strong) begin
					mode_d = MODE_SHAKING;
					pick   = 1'b1;
				end
			end
		endcase
		letter_d = pick ? mod26(lfsr_nxt) : letter_q;
		ascii_d  = 7'(letter_q) + LETTER_BASE;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			letter_q <= '0;
			timer_q  <= '0;
			lfsr_q   <= SEED_RST;
		end else begin
			if (seed_load) begin
				lfsr_q <= (random_seed == '0) ? 16'd1 : random_seed;
			end else if (en && item.valid && pick) begin
				lfsr_q <= lfsr_nxt;
			end
			if (en && item.valid) begin
				mode_q   <= mode_d;
				letter_q <= letter_d;
				timer_q  <= timer_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_res_q <= mode_d;
			shown_q    <= 7'(letter_d) + LETTER_BASE;
			key_q      <= key_d;
			ascii_q    <= key_d ? ascii_d : 7'd0;
			usage_q    <= key_d ? 5'(ascii_d - USAGE_OFFSET) : 5'd0;
		end
	end

	assign res_valid    = res_valid_q;
	assign mode_now     = mode_res_q;
	assign shown_letter = shown_q;
	assign key_valid    = key_q;
	assign key_ascii    = ascii_q;
	assign key_usage    = usage_q;

	// a key is only entered on the way back to idle
	a_key_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && key_q) |-> (mode_res_q == MODE_IDLE))
		else $error("key entered without returning to idle");

	// a strong sample in idle always starts shaking
	a_idle_strong: assert property (@(posedge clk) disable iff (!arst_n)
		(en && item.valid && item.is_strong && mode_q == MODE_IDLE) |=> (mode_q == MODE_SHAKING))
		else $error("strong sample in idle did not start shaking");

	// the lfsr must never lock at zero
	a_lfsr_live: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != 16'd0)
		else $error("letter lfsr reached zero");

	// entering settling restarts the timer
	a_timer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(en && item.valid && mode_q == MODE_SHAKING && !item.is_strong) |=> (timer_q == '0))
		else $error("settle timer not cleared on entering settling");

endmodule

>>> sv/shake_gesture_key_selector.sv
// Shake gesture key selector: one accelerometer sample in, one status result out.
//
// Input stream (s_*): each request carries accel_x/y/z and the microseconds since
// the previous sample. Output stream (m_*): one result per sample with the mode,
// the letter on show and, when the sample ended a settle period, the entered key
// as ASCII and keyboard usage code (m_tuser high marks a key).
// Configuration: cfg_we writes cfg_data into register cfg_index (0 shake
// threshold, 1 settle timeout in microseconds, 2 lfsr seed, which also reloads
// the lfsr). Write only while no sample is in flight.
// Throughput is one sample per cycle while no waiting result holds the pipeline:
// four feed-forward stages (capture, squares, threshold test and dot products,
// dot sum) feed a combinational mode update that writes the result register on m_*.
// Reset clears all pipeline valids, puts the block in idle with letter A, loads
// the register reset values and the lfsr from the reset seed.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops in the same cycle; no request is lost or repeated.
`timescale 1ns / 1ps

module shake_gesture_key_selector import skg_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int TIMER_BITS  = DEF_TIMER_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// sample input
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// accel_x, accel_y, accel_z, elapsed_us, zero padding
	input  logic [((3*SAMPLE_BITS+ELAPSED_W+7)/8)*8-1:0] s_tdata,
	// result output
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// mode_now, shown_letter, key_ascii, key_usage, zero padding
	output logic [23:0]          m_tdata,
	// key_valid
	output logic                 m_tuser
);

	localparam int SB = SAMPLE_BITS;

	logic [THRESH_W-1:0]  thresh_q;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic                 seed_load;
	logic                 en;
	skg_item_t            item;
	logic                 res_valid;
	logic [1:0]           mode_now;
	logic [6:0]           shown_letter;
	logic                 key_valid;
	logic [6:0]           key_ascii;
	logic [4:0]           key_usage;

	// configuration registers; the seed goes straight into the lfsr
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q  <= THRESH_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: thresh_q  <= cfg_data[THRESH_W-1:0];
				REG_TIMEOUT:   timeout_q <= cfg_data[TIMEOUT_W-1:0];
				REG_SEED:      ;
				default: ;
			endcase
		end
	end

	assign seed_load = cfg_we && (cfg_index == REG_SEED);

	// pipeline advances whenever the result register is free or being taken
	assign en       = !res_valid || m_tready;
	assign s_tready = en;

	skg_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (s_tvalid),
		.accel_x        (s_tdata[SB-1:0]),
		.accel_y        (s_tdata[2*SB-1:SB]),
		.accel_z        (s_tdata[3*SB-1:2*SB]),
		.elapsed_us     (s_tdata[3*SB+ELAPSED_W-1:3*SB]),
		.shake_threshold(thresh_q),
		.item           (item)
	);

	skg_core #(
		.TIMER_BITS(TIMER_BITS)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (en),
		.item             (item),
		.settle_timeout_us(timeout_q),
		.seed_load        (seed_load),
		.random_seed      (cfg_data[SEED_W-1:0]),
		.res_valid        (res_valid),
		.mode_now         (mode_now),
		.shown_letter     (shown_letter),
		.key_valid        (key_valid),
		.key_ascii        (key_ascii),
		.key_usage        (key_usage)
	);

	// result packing
	assign m_tvalid = res_valid;
	assign m_tdata  = {3'b000, key_usage, key_ascii, shown_letter, mode_now};
	assign m_tuser  = key_valid;

endmodule

>>> test/tb.sv
// self-checking bench for the shake gesture key selector: directed and random samples
`timescale 1ns / 1ps

module tb;
	import skg_pkg::*;

	localparam int                 STALL_LIMIT  = 1000;
	localparam int                 DRAIN_CYCLES = 10;
	localparam int                 LETTER_COUNT = 26;
	localparam longint             TIMER_MAX    = (longint'(1) << DEF_TIMER_BITS) - 1;
	// index past the register list, written to show it is ignored
	localparam logic [1:0]         REG_UNUSED   = 2'd3;

	// one accelerometer request
	typedef struct {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic [15:0]        elapsed;
	} sample_t;

	// one status result
	typedef struct packed {
		logic [1:0] mode_now;
		logic [6:0] letter;
		logic       key_valid;
		logic [6:0] key_ascii;
		logic [4:0] key_usage;
	} status_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [1:0]       cfg_index = 2'd0;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	// accel_x, accel_y, accel_z, elapsed_us
	logic [63:0]      s_tdata   = '0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	// mode_now, shown_letter, key_ascii, key_usage, zero padding
	logic [23:0]      m_tdata;
	// key_valid
	logic             m_tuser;

	sample_t sample_q[$];
	status_t status_q[$];
	int      queued_total  = 0;
	int      fail_count    = 0;
	int      stall_cycles  = 0;
	int      send_idle_pct = 34;
	int      recv_idle_pct = 48;

	// predictor state and register copies
	logic [THRESH_W-1:0]  thr_reg     = THRESH_RST;
	logic [TIMEOUT_W-1:0] timeout_reg = TIMEOUT_RST;
	logic [1:0]           sel_mode    = MODE_IDLE;
	logic [4:0]           letter_idx  = 5'd0;
	logic signed [15:0]   held_vec[3] = '{16'sd0, 16'sd0, 16'sd0};
	longint               settle_cnt  = 0;
	logic [15:0]          lfsr_state  = SEED_RST;

	shake_gesture_key_selector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #1 clk = ~clk;

	// advance the letter lfsr one step and pick the letter from it
	function automatic void pick_next_letter();
		logic lsb;
		lsb = lfsr_state[0];
		lfsr_state = lfsr_state >> 1;
		if (lsb) begin
			lfsr_state = lfsr_state ^ LFSR_MASK;
		end
		letter_idx = 5'(lfsr_state % LETTER_COUNT);
	endfunction

	// strong sample while shaking or settling: reverse of direction reselects the letter
	function automatic void track_swing(input sample_t s);
		longint dot;
		dot = longint'(held_vec[0]) * longint'(s.ax) + longint'(held_vec[1]) * longint'(s.ay)
			+ longint'(held_vec[2]) * longint'(s.az);
		held_vec[0] = s.ax;
		held_vec[1] = s.ay;
		held_vec[2] = s.az;
		if (dot < 0) begin
			pick_next_letter();
		end
	endfunction

	// expected status after one sample, updating the predictor state
	function automatic status_t predict_status(input sample_t s);
		status_t r;
		longint  mag2;
		longint  thr2;
		logic    is_strong;
		r = '0;
		mag2 = longint'(s.ax) * longint'(s.ax) + longint'(s.ay) * longint'(s.ay)
			+ longint'(s.az) * longint'(s.az);
		thr2 = longint'(thr_reg) * longint'(thr_reg);
		is_strong = (mag2 >= thr2);
		case (sel_mode)
			MODE_SHAKING: begin
				if (!is_strong) begin
					sel_mode = MODE_SETTLING;
					settle_cnt = 0;
				end else begin
					track_swing(s);
				end
			end
			MODE_SETTLING: begin
				if (is_strong) begin
					sel_mode = MODE_SHAKING;
					track_swing(s);
				end else begin
					settle_cnt = settle_cnt + longint'(s.elapsed);
					if (settle_cnt > TIMER_MAX) begin
						settle_cnt = TIMER_MAX;
					end
					if (settle_cnt > longint'(timeout_reg)) begin
						r.key_valid = 1'b1;
						r.key_ascii = 7'(letter_idx) + LETTER_BASE;
						r.key_usage = 5'(r.key_ascii - USAGE_OFFSET);
						sel_mode = MODE_IDLE;
						held_vec = '{16'sd0, 16'sd0, 16'sd0};
					end
				end
			end
			default: begin
				sel_mode = MODE_IDLE;
				if (is_strong) begin
					held_vec[0] = s.ax;
					held_vec[1] = s.ay;
					held_vec[2] = s.az;
					sel_mode = MODE_SHAKING;
					pick_next_letter();
				end
			end
		endcase
		r.mode_now = sel_mode;
		r.letter = 7'(letter_idx) + LETTER_BASE;
		return r;
	endfunction

	task automatic note_failure(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want) begin
			note_failure($sformatf("%s got %0d want %0d", name, got, want));
		end
	endtask

	function automatic int rand_full();
		return int'($urandom_range(65535)) - 32768;
	endfunction

	task automatic push_sample(input int x, input int y, input int z, input int el);
		sample_t s;
		s.ax = 16'(x);
		s.ay = 16'(y);
		s.az = 16'(z);
		s.elapsed = 16'(el);
		sample_q.push_back(s);
		queued_total++;
	endtask

	// sample with one axis at or above the threshold
	task automatic push_strong();
		int c[3];
		int mag_lo;
		int k;
		mag_lo = (thr_reg > 32767) ? 32767 : int'(thr_reg);
		for (int i = 0; i < 3; i++) begin
			c[i] = $urandom_range(1) ? rand_full() : int'($urandom_range(64)) - 32;
		end
		k = $urandom_range(2);
		c[k] = $urandom_range(32767, mag_lo);
		if ($urandom_range(1)) begin
			c[k] = -c[k];
		end
		push_sample(c[0], c[1], c[2], $urandom_range(65535));
	endtask

	// sample kept below the threshold on every axis
	task automatic push_weak(input int el);
		int half;
		half = thr_reg / 2;
		push_sample(int'($urandom_range(2 * half)) - half, int'($urandom_range(2 * half)) - half,
			int'($urandom_range(2 * half)) - half, el);
	endtask

	// shake, optional lulls, then calm long enough to enter the key
	task automatic queue_gesture();
		longint sum;
		int     lo;
		int     e;
		int     guard;
		repeat ($urandom_range(4, 1)) begin
			push_strong();
			if ($urandom_range(3) == 0) begin
				push_weak($urandom_range(65535));
			end
		end
		push_weak($urandom_range(65535));
		lo = (timeout_reg / 5 > 65535) ? 65535 : int'(timeout_reg / 5);
		sum = 0;
		guard = 0;
		while (sum <= longint'(timeout_reg) && guard < 300) begin
			e = $urandom_range(65535, lo);
			push_weak(e);
			sum += e;
			guard++;
		end
		repeat ($urandom_range(2)) begin
			push_weak($urandom_range(65535));
		end
	endtask

	task automatic run_random(input int n, input bit noise_only);
		int target;
		target = queued_total + n;
		while (queued_total < target) begin
			if (noise_only || $urandom_range(4) == 0) begin
				push_sample(rand_full(), rand_full(), rand_full(), $urandom_range(65535));
			end else begin
				queue_gesture();
			end
		end
	endtask

	// wait for every request and result, then let the pipeline empty
	task automatic drain();
		do begin
			@(negedge clk);
		end while (sample_q.size() != 0 || s_tvalid || status_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_THRESHOLD: thr_reg = data[THRESH_W-1:0];
			REG_TIMEOUT:   timeout_reg = data[TIMEOUT_W-1:0];
			REG_SEED: begin
				lfsr_state = data[SEED_W-1:0];
				if (lfsr_state == 16'd0) begin
					lfsr_state = 16'd1;
				end
			end
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] tmo,
		input logic [CFG_W-1:0] seed);
		cfg_write(REG_THRESHOLD, thr);
		cfg_write(REG_TIMEOUT, tmo);
		cfg_write(REG_SEED, seed);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// request driver
	always @(posedge clk) begin : driver
		sample_t s;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s = sample_q.pop_front();
				s_tdata <= {s.elapsed, s.az, s.ay, s.ax};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// prediction on accepted requests, checking of accepted results, watchdog
	always @(posedge clk) begin : monitor
		sample_t s;
		status_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				s.ax = s_tdata[15:0];
				s.ay = s_tdata[31:16];
				s.az = s_tdata[47:32];
				s.elapsed = s_tdata[63:48];
				status_q.push_back(predict_status(s));
			end
			if (m_tvalid && m_tready) begin
				if (status_q.size() == 0) begin
					note_failure("result with no sample waiting");
				end else begin
					want = status_q.pop_front();
					compare_field("mode_now", m_tdata[1:0], want.mode_now);
					compare_field("shown_letter", m_tdata[8:2], want.letter);
					compare_field("key_valid", m_tuser, want.key_valid);
					compare_field("key_ascii", m_tdata[15:9], want.key_ascii);
					compare_field("key_usage", m_tdata[20:16], want.key_usage);
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// stimulus phases
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: threshold edges, reversals, exact timeout boundary
		push_sample(0, 0, 0, 0);
		push_sample(249, 0, 0, 65535);
		push_sample(250, 0, 0, 0);
		push_sample(-32768, -32768, -32768, 0);
		push_sample(32767, 32767, 32767, 0);
		push_sample(32767, -32768, 0, 0);
		push_sample(32767, -32768, 0, 0);
		push_sample(0, 176, 176, 12345);
		push_sample(-32767, 32767, 0, 0);
		push_sample(0, 0, 0, 65535);
		repeat (7) push_sample(0, 0, 0, 50000);
		push_sample(0, 0, 0, 0);
		push_sample(0, 0, 0, 1);
		push_sample(0, 0, 0, 65535);
		run_random(150, 1'b0);
		drain();

		// zero threshold, timeout of one microsecond, zero seed, dropped upper bits
		cfg_write(REG_UNUSED, 24'hFFFFFF);
		set_config(24'hAB0000, 24'd1, 24'h5A0000);
		push_sample(0, 0, 0, 0);
		run_random(60, 1'b0);
		drain();

		// largest settings: nothing can be strong
		send_idle_pct = 48;
		recv_idle_pct = 34;
		set_config(24'hFFFF, 24'hFFFFFF, 24'hFFFF);
		push_sample(-32768, -32768, -32768, 65535);
		push_sample(32767, 32767, 32767, 0);
		run_random(30, 1'b1);
		drain();

		// zero timeout: any nonzero calm time enters the key
		set_config(24'd3000, 24'd0, 24'($urandom_range(65535, 1)));
		push_sample(3000, 0, 0, 5);
		push_sample(0, 0, 0, 0);
		push_sample(0, 0, 0, 0);
		push_sample(0, 0, 0, 1);
		run_random(150, 1'b0);
		drain();

		// random settings with no idling
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(24'($urandom_range(20000, 100)), 24'($urandom_range(200000, 1)),
			24'($urandom_range(65535, 1)));
		run_random(160, 1'b0);
		drain();

		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
